[rtl/core/cfp_pkg.sv]
// Shared types and constants for the command frame parser.
// Used by the front, the queue, the back and the top level; no dependencies.
package cfp_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam int unsigned NUM_CAP = 9;
  localparam int unsigned NUM_ARGS = 7;
  localparam logic [3:0] CAP_FIRST = 4'd5;
  localparam logic [3:0] CAP_LAST = 4'd13;
  localparam logic [3:0] IDX_SAT = 4'd14;

  localparam logic [1:0] CFG_LED = 2'd0;
  localparam logic [1:0] CFG_RTC = 2'd1;
  localparam logic [1:0] CFG_ALARM = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SYNC2,
    PH_LENHI,
    PH_LENLO,
    PH_BODY,
    PH_CHECK
  } phase_t;

  typedef enum logic [1:0] {
    K_START,
    K_BAD,
    K_BYTE,
    K_FINISH
  } kind_t;

  typedef enum logic [1:0] {
    CHK_KEEP,
    CHK_LOAD,
    CHK_XOR
  } chk_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD_SYNC,
    ST_BAD_CHECK
  } status_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_LED,
    ACT_RTC,
    ACT_ALARM
  } action_t;

  // One classified byte, handed from the front to the back.
  typedef struct packed {
    kind_t      kind;
    chk_t       chk;
    logic       cap_valid;
    logic [3:0] cap_sel;
    logic [7:0] data;
  } op_t;

  typedef struct packed {
    logic [7:0] led;
    logic [7:0] rtc;
    logic [7:0] alarm;
  } cmd_codes_t;

  typedef struct packed {
    status_t                   status;
    logic [7:0]                check;
    logic [7:0]                sequence_res;
    logic [7:0]                command;
    action_t                   action;
    logic [NUM_ARGS-1:0][7:0]  args;
  } result_t;

endpackage

[rtl/core/cfp_front.sv]
// Front of the command frame parser: tracks the frame layout and classifies
// each accepted byte into an operation for the back. Depends on cfp_pkg.
module cfp_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    data_byte,
  input  logic          frame_start,
  output logic          push,
  output cfp_pkg::op_t  op
);
  import cfp_pkg::*;

  phase_t      phase, phase_next;
  logic [15:0] remaining, remaining_next;
  logic [3:0]  index, index_next;
  logic [15:0] len_word;

  assign len_word = {remaining[15:8], data_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      remaining <= '0;
      index <= '0;
    end else begin
      phase <= phase_next;
      remaining <= remaining_next;
      index <= index_next;
    end
  end

  // Next state.
  always_comb begin
    phase_next = phase;
    remaining_next = remaining;
    index_next = index;
    if (accept) begin
      if (frame_start) begin
        phase_next = (data_byte == SYNC_BYTE) ? PH_SYNC2 : PH_IDLE;
        remaining_next = '0;
        index_next = 4'd1;
      end else if (phase != PH_IDLE) begin
        index_next = (index == IDX_SAT) ? index : index + 4'd1;
        case (phase)
          PH_SYNC2: begin
            phase_next = (data_byte == SYNC_BYTE) ? PH_LENHI : PH_IDLE;
          end
          PH_LENHI: begin
            remaining_next = {data_byte, 8'h00};
            phase_next = PH_LENLO;
          end
          PH_LENLO: begin
            if (len_word == 16'd0) begin
              phase_next = PH_IDLE;
            end else begin
              remaining_next = len_word - 16'd1;
              phase_next = (len_word == 16'd1) ? PH_CHECK : PH_BODY;
            end
          end
          PH_BODY: begin
            remaining_next = remaining - 16'd1;
            if (remaining == 16'd1) begin
              phase_next = PH_CHECK;
            end
          end
          PH_CHECK: begin
            phase_next = PH_IDLE;
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  // Outputs: one operation per byte that matters to the back.
  always_comb begin
    push = 1'b0;
    op.kind = K_BYTE;
    op.chk = CHK_KEEP;
    op.data = data_byte;
    op.cap_valid = !frame_start && (index >= CAP_FIRST) && (index <= CAP_LAST);
    op.cap_sel = index - CAP_FIRST;
    if (accept) begin
      if (frame_start) begin
        push = 1'b1;
        op.kind = (data_byte == SYNC_BYTE) ? K_START : K_BAD;
      end else begin
        case (phase)
          PH_SYNC2: begin
            if (data_byte != SYNC_BYTE) begin
              push = 1'b1;
              op.kind = K_BAD;
            end
          end
          PH_LENHI: begin
            push = 1'b1;
            op.chk = CHK_LOAD;
          end
          PH_LENLO: begin
            push = 1'b1;
            if (len_word == 16'd0) begin
              op.kind = K_FINISH;
            end else begin
              op.chk = CHK_XOR;
            end
          end
          PH_BODY: begin
            push = 1'b1;
            op.chk = CHK_XOR;
          end
          PH_CHECK: begin
            push = 1'b1;
            op.kind = K_FINISH;
          end
          default: begin
            push = 1'b0;
          end
        endcase
      end
    end
  end

endmodule

[rtl/core/cfp_queue.sv]
// Short queue of classified operations between front and back.
// Depends on cfp_pkg for the entry type.
module cfp_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cfp_pkg::op_t  push_op,
  output logic          full,
  output logic          head_valid,
  output cfp_pkg::op_t  head_op,
  input  logic          pop
);
  import cfp_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  op_t              entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_op = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/core/cfp_back.sv]
// Back of the command frame parser: folds the check, captures frame bytes
// and builds the registered result. Depends on cfp_pkg.
module cfp_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  cfp_pkg::op_t        head_op,
  output logic                pop,
  input  cfp_pkg::cmd_codes_t codes,
  output logic                out_valid,
  input  logic                out_ready,
  output cfp_pkg::result_t    result
);
  import cfp_pkg::*;

  logic [7:0] cap [NUM_CAP];
  logic [7:0] cap_next [NUM_CAP];
  logic [7:0] check, check_next;
  logic       needs_out, slot_free, emit;
  result_t    result_next;

  assign needs_out = (head_op.kind == K_BAD) || (head_op.kind == K_FINISH);
  assign slot_free = !out_valid || out_ready;
  assign pop = head_valid && (!needs_out || slot_free);
  assign emit = pop && needs_out;

  always_comb begin
    for (int i = 0; i < NUM_CAP; i++) begin
      if (head_op.kind == K_START || head_op.kind == K_BAD) begin
        cap_next[i] = '0;
      end else if (head_op.cap_valid && head_op.cap_sel == 4'(i)) begin
        cap_next[i] = head_op.data;
      end else begin
        cap_next[i] = cap[i];
      end
    end
  end

  always_comb begin
    check_next = check;
    if (head_op.kind == K_START || head_op.kind == K_BAD) begin
      check_next = '0;
    end else begin
      case (head_op.chk)
        CHK_LOAD: check_next = head_op.data;
        CHK_XOR:  check_next = check ^ head_op.data;
        default:  check_next = check;
      endcase
    end
  end

  // Result of the operation at the head; used only when it emits.
  always_comb begin
    result_next = '0;
    if (head_op.kind == K_BAD) begin
      result_next.status = ST_BAD_SYNC;
    end else begin
      result_next.status = (check == head_op.data) ? ST_OK : ST_BAD_CHECK;
      result_next.check = check;
      result_next.sequence_res = cap_next[0];
      for (int j = 0; j < NUM_ARGS; j++) begin
        result_next.args[j] = cap_next[j + 2];
      end
      if (check == head_op.data) begin
        result_next.command = cap_next[1];
        if (cap_next[1] == codes.led) begin
          result_next.action = ACT_LED;
        end else if (cap_next[1] == codes.rtc) begin
          result_next.action = ACT_RTC;
        end else if (cap_next[1] == codes.alarm) begin
          result_next.action = ACT_ALARM;
        end else begin
          result_next.action = ACT_NONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      check <= '0;
      for (int i = 0; i < NUM_CAP; i++) begin
        cap[i] <= '0;
      end
    end else if (pop) begin
      check <= check_next;
      for (int i = 0; i < NUM_CAP; i++) begin
        cap[i] <= cap_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= result_next;
    end
  end

endmodule

[rtl/core/command_frame_parser_core.sv]
// Top level of the command frame parser: command code registers, front,
// queue and back. Depends on cfp_pkg, cfp_front, cfp_queue and cfp_back.
//
//   channel  direction  handshake              beat contents
//   input    in         in_valid / in_ready    data_byte, frame_start
//   result   out        out_valid / out_ready  status, computed_check,
//                                              sequence_res, command, action,
//                                              arg_byte0 .. arg_byte6
//   config   in         cfg_we (no wait)       cfg_index, cfg_data
//
// The block takes one input beat per cycle while the queue has room. A byte
// enters the queue when it is accepted; a result is loaded into the output
// register when the back retires the closing operation from the queue head.
// The sustained rate is set by the back retiring one entry per cycle; only a
// result that waits on out_ready stops the back, and input stalls once the
// QUEUE_DEPTH entries have filled.
// Reset is synchronous and clears the parse state, the queue, the output
// valid and sets the command codes to their defaults.
module command_frame_parser_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       frame_start,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] status,
  output logic [7:0] computed_check,
  output logic [7:0] sequence_res,
  output logic [7:0] command,
  output logic [1:0] action,
  output logic [7:0] arg_byte0,
  output logic [7:0] arg_byte1,
  output logic [7:0] arg_byte2,
  output logic [7:0] arg_byte3,
  output logic [7:0] arg_byte4,
  output logic [7:0] arg_byte5,
  output logic [7:0] arg_byte6,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import cfp_pkg::*;

  cmd_codes_t codes;
  logic       accept;
  logic       push, full, head_valid, pop;
  op_t        push_op, head_op;
  result_t    result;

  // Command code registers. An index past the last register is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      codes.led <= 8'd1;
      codes.rtc <= 8'd4;
      codes.alarm <= 8'd5;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LED:   codes.led <= cfg_data;
        CFG_RTC:   codes.rtc <= cfg_data;
        CFG_ALARM: codes.alarm <= cfg_data;
        default:   codes <= codes;
      endcase
    end
  end

  // Input is taken whenever the queue can hold the beat's operation. Bytes
  // that produce no operation are still only taken then, which keeps the
  // ready path free of the parse state.
  assign in_ready = !full;
  assign accept = in_valid && in_ready;

  cfp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (data_byte),
    .frame_start (frame_start),
    .push        (push),
    .op          (push_op)
  );

  cfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .full       (full),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (pop)
  );

  cfp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (pop),
    .codes      (codes),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result     (result)
  );

  assign status = result.status;
  assign computed_check = result.check;
  assign sequence_res = result.sequence_res;
  assign command = result.command;
  assign action = result.action;
  assign arg_byte0 = result.args[0];
  assign arg_byte1 = result.args[1];
  assign arg_byte2 = result.args[2];
  assign arg_byte3 = result.args[3];
  assign arg_byte4 = result.args[4];
  assign arg_byte5 = result.args[5];
  assign arg_byte6 = result.args[6];

  // A bad header carries nothing but its status.
  a_bad_sync_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_BAD_SYNC |->
      computed_check == 8'd0 && sequence_res == 8'd0 && arg_byte0 == 8'd0)
    else $error("bad sync result carries frame data");

  // Command and action are reported only for a frame that checked out.
  a_action_needs_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action != ACT_NONE || command != 8'd0) |-> status == ST_OK)
    else $error("command or action reported on a failed frame");

  // The back never retires an operation while the queue is empty.
  a_pop_has_entry: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue popped while empty");

  // A new result is loaded only into a free output slot.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(computed_check))
    else $error("pending result overwritten");

endmodule
